/* src/vpg_pkg.sv */
`default_nettype none
package vpg_pkg;

  localparam int COORD_BITS   = 16;
  localparam int PROD_W       = 2 * COORD_BITS;
  localparam int DOT_W        = PROD_W + 1;
  localparam int SQ_W         = 2 * PROD_W;
  localparam int ROOT_W       = PROD_W;
  localparam int REM_W        = PROD_W + 3;
  localparam int SQRT_STEPS   = SQ_W / 2;
  localparam int NORM_W       = 40;
  localparam int NORM_STEPS   = 6;
  localparam int CW           = 44;
  localparam int ZW           = 24;
  localparam int CORDIC_STEPS = 20;
  localparam int ANGLE_W      = 16;
  localparam int AREA_W       = 31;
  localparam int STEP_W       = 6;

  localparam logic signed [ZW-1:0] HALF_PI_Z = 24'sd1647099;
  localparam logic signed [ZW-1:0] PI_Z      = 24'sd3294199;
  localparam logic [ANGLE_W-1:0]   ANGLE_MAX = 16'd51472;

  typedef struct packed {
    logic                    undef;
    logic signed [DOT_W-1:0] dot;
    logic [AREA_W-1:0]       area;
  } side_t;

  // arctan(2^-i) in units of 2^-20 rad
  function automatic logic signed [ZW-1:0] atan_z(input int step);
    logic signed [ZW-1:0] r;
    case (step)
      0:       r = 24'sd823550;
      1:       r = 24'sd486170;
      2:       r = 24'sd256879;
      3:       r = 24'sd130396;
      4:       r = 24'sd65451;
      5:       r = 24'sd32757;
      6:       r = 24'sd16383;
      7:       r = 24'sd8192;
      8:       r = 24'sd4096;
      9:       r = 24'sd2048;
      10:      r = 24'sd1024;
      11:      r = 24'sd512;
      12:      r = 24'sd256;
      13:      r = 24'sd128;
      14:      r = 24'sd64;
      15:      r = 24'sd32;
      16:      r = 24'sd16;
      17:      r = 24'sd8;
      18:      r = 24'sd4;
      19:      r = 24'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/vpg_front.sv */
`default_nettype none
module vpg_front (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  en_i,
  input  wire logic                                  valid_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_x_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_y_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_z_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_x_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_y_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_z_i,
  output logic                                       valid_o,
  output vpg_pkg::side_t                             side_o,
  output logic [vpg_pkg::SQ_W-1:0]                   sum_sq_o
);
  import vpg_pkg::*;

  logic [3:0] valid_q;
  logic       undef_a_q, undef_b_q, undef_c_q, undef_d_q;

  logic signed [PROD_W-1:0] prod_q [9];
  logic signed [PROD_W-1:0] prod_d [9];

  logic signed [DOT_W-1:0] dot_b_q, dot_c_q, dot_d_q, dot_b_d;
  logic signed [DOT_W-1:0] cross_d [3];
  logic [PROD_W-1:0]       mag_q [3];
  logic [PROD_W-1:0]       mag_d [3];
  logic [SQ_W-1:0]         sq_q [3];
  logic [SQ_W-1:0]         sum_q;
  logic                    undef_a_d;

  always_comb begin
    prod_d[0] = v1_x_i * v2_x_i;
    prod_d[1] = v1_y_i * v2_y_i;
    prod_d[2] = v1_z_i * v2_z_i;
    prod_d[3] = v1_y_i * v2_z_i;
    prod_d[4] = v1_z_i * v2_y_i;
    prod_d[5] = v1_x_i * v2_z_i;
    prod_d[6] = v1_z_i * v2_x_i;
    prod_d[7] = v1_x_i * v2_y_i;
    prod_d[8] = v1_y_i * v2_x_i;
    undef_a_d = ((v1_x_i == '0) && (v1_y_i == '0) && (v1_z_i == '0)) ||
                ((v2_x_i == '0) && (v2_y_i == '0) && (v2_z_i == '0));
  end

  always_comb begin
    dot_b_d = DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]);
    cross_d[0] = DOT_W'(prod_q[3]) - DOT_W'(prod_q[4]);
    cross_d[1] = DOT_W'(prod_q[5]) - DOT_W'(prod_q[6]);
    cross_d[2] = DOT_W'(prod_q[7]) - DOT_W'(prod_q[8]);
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = cross_d[i][DOT_W-1] ? PROD_W'(-cross_d[i]) : PROD_W'(cross_d[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q    <= prod_d;
      undef_a_q <= undef_a_d;
      dot_b_q   <= dot_b_d;
      mag_q     <= mag_d;
      undef_b_q <= undef_a_q;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= SQ_W'(mag_q[i]) * SQ_W'(mag_q[i]);
      end
      dot_c_q   <= dot_b_q;
      undef_c_q <= undef_b_q;
      sum_q     <= sq_q[0] + sq_q[1] + sq_q[2];
      dot_d_q   <= dot_c_q;
      undef_d_q <= undef_c_q;
    end
  end

  assign valid_o      = valid_q[3];
  assign sum_sq_o     = sum_q;
  assign side_o.undef = undef_d_q;
  assign side_o.dot   = dot_d_q;
  assign side_o.area  = '0;

endmodule
`default_nettype wire

/* src/vpg_sqrt_cell.sv */
`default_nettype none
module vpg_sqrt_cell (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         en_i,
  input  wire logic                         valid_i,
  input  wire vpg_pkg::side_t               side_i,
  input  wire logic [vpg_pkg::SQ_W-1:0]     rad_i,
  input  wire logic [vpg_pkg::REM_W-1:0]    rem_i,
  input  wire logic [vpg_pkg::ROOT_W-1:0]   root_i,
  output logic                              valid_o,
  output vpg_pkg::side_t                    side_o,
  output logic [vpg_pkg::SQ_W-1:0]          rad_o,
  output logic [vpg_pkg::REM_W-1:0]         rem_o,
  output logic [vpg_pkg::ROOT_W-1:0]        root_o
);
  import vpg_pkg::*;

  logic                valid_q;
  side_t               side_q;
  logic [SQ_W-1:0]     rad_q, rad_d;
  logic [REM_W-1:0]    rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0]   root_q, root_d;
  logic                ge;

  // one result bit per cell: bring down two radicand bits, try (4r + 1)
  always_comb begin
    rem_sh = {rem_i[REM_W-3:0], rad_i[SQ_W-1 -: 2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_i, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? (rem_sh - trial) : rem_sh;
    root_d = {root_i[ROOT_W-2:0], ge};
    rad_d  = {rad_i[SQ_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire

/* src/vpg_norm_cell.sv */
`default_nettype none
module vpg_norm_cell (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic [vpg_pkg::STEP_W-1:0]  shift_i,
  input  wire logic                        valid_i,
  input  wire vpg_pkg::side_t              side_i,
  input  wire logic [vpg_pkg::NORM_W-1:0]  x_i,
  input  wire logic [vpg_pkg::NORM_W-1:0]  y_i,
  input  wire logic signed [vpg_pkg::ZW-1:0] z_i,
  output logic                             valid_o,
  output vpg_pkg::side_t                   side_o,
  output logic [vpg_pkg::NORM_W-1:0]       x_o,
  output logic [vpg_pkg::NORM_W-1:0]       y_o,
  output logic signed [vpg_pkg::ZW-1:0]    z_o
);
  import vpg_pkg::*;

  logic               valid_q;
  side_t              side_q;
  logic [NORM_W-1:0]  x_q, y_q, x_d, y_d, top_mask;
  logic signed [ZW-1:0] z_q;
  logic               room;

  // shift left by this cell's amount when the top bits are clear in both
  always_comb begin
    top_mask = ~({NORM_W{1'b1}} >> shift_i);
    room     = ((x_i | y_i) & top_mask) == '0;
    x_d      = room ? (x_i << shift_i) : x_i;
    y_d      = room ? (y_i << shift_i) : y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

/* src/vpg_cordic_cell.sv */
`default_nettype none
module vpg_cordic_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic [vpg_pkg::STEP_W-1:0]    step_i,
  input  wire logic signed [vpg_pkg::ZW-1:0] atan_i,
  input  wire logic                          valid_i,
  input  wire vpg_pkg::side_t                side_i,
  input  wire logic signed [vpg_pkg::CW-1:0] x_i,
  input  wire logic signed [vpg_pkg::CW-1:0] y_i,
  input  wire logic signed [vpg_pkg::ZW-1:0] z_i,
  output logic                               valid_o,
  output vpg_pkg::side_t                     side_o,
  output logic signed [vpg_pkg::CW-1:0]      x_o,
  output logic signed [vpg_pkg::CW-1:0]      y_o,
  output logic signed [vpg_pkg::ZW-1:0]      z_o
);
  import vpg_pkg::*;

  logic                 valid_q;
  side_t                side_q;
  logic signed [CW-1:0] x_q, y_q, x_d, y_d, dx, dy;
  logic signed [ZW-1:0] z_q, z_d;

  // rotate towards y = 0
  always_comb begin
    dx = y_i >>> step_i;
    dy = x_i >>> step_i;
    if (!y_i[CW-1]) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_i;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

/* src/vector_pair_geometry_core.sv */
// vector_pair_geometry_core: dot product, angle and triangle area of two 3D vectors
//
// input channel: valid_i / stall_o with six signed Q8.8 coordinates, one request
// per pair of vectors. output channel: valid_o / stall_i with the dot product
// (signed Q16.16), the angle in radians (Q2.14, 0 to pi), an undefined-angle
// flag for a zero vector and the triangle area (Q15.16).
// the block is a pipeline of register cells: four product and sum stages,
// 32 square-root cells (one root bit each), a set-up stage, six normalising
// cells and 20 cordic cells, then the output register. one request is taken
// every cycle while the pipeline is not stalled.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// stall_o rises; bubbles are not squeezed out, so empty stages hold as well.
// reset clears all valid flags; the pipeline is empty and ready afterwards.
// a zero vector gives angle 0 with the flag set; dot and area are still given.
`default_nettype none
module vector_pair_geometry_core (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       stall_o,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_x_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_y_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v1_z_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_x_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_y_i,
  input  wire logic signed [vpg_pkg::COORD_BITS-1:0] v2_z_i,
  output logic                                       valid_o,
  input  wire logic                                  stall_i,
  output logic signed [vpg_pkg::DOT_W-1:0]           dot_value_o,
  output logic [vpg_pkg::ANGLE_W-1:0]                angle_rad_o,
  output logic                                       angle_undefined_o,
  output logic [vpg_pkg::AREA_W-1:0]                 triangle_area_o
);
  import vpg_pkg::*;

  logic en;

  logic            f_valid;
  side_t           f_side;
  logic [SQ_W-1:0] f_sum;

  logic              sq_valid [SQRT_STEPS+1];
  side_t             sq_side  [SQRT_STEPS+1];
  logic [SQ_W-1:0]   sq_rad   [SQRT_STEPS+1];
  logic [REM_W-1:0]  sq_rem   [SQRT_STEPS+1];
  logic [ROOT_W-1:0] sq_root  [SQRT_STEPS+1];

  logic                 e_valid_q;
  side_t                e_side_q, e_side_d;
  logic [NORM_W-1:0]    e_x_q, e_y_q, e_x_d, e_y_d;
  logic signed [ZW-1:0] e_z_q, e_z_d;
  logic [DOT_W-1:0]     dmag;
  logic [ROOT_W:0]      root_inc;

  logic                 n_valid [NORM_STEPS+1];
  side_t                n_side  [NORM_STEPS+1];
  logic [NORM_W-1:0]    n_x     [NORM_STEPS+1];
  logic [NORM_W-1:0]    n_y     [NORM_STEPS+1];
  logic signed [ZW-1:0] n_z     [NORM_STEPS+1];

  logic                 c_valid [CORDIC_STEPS+1];
  side_t                c_side  [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_x     [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_y     [CORDIC_STEPS+1];
  logic signed [ZW-1:0] c_z     [CORDIC_STEPS+1];

  logic                    out_valid_q;
  logic signed [DOT_W-1:0] out_dot_q;
  logic [ANGLE_W-1:0]      out_angle_q, out_angle_d;
  logic                    out_undef_q;
  logic [AREA_W-1:0]       out_area_q;
  logic signed [ZW-1:0]    z_clamped;
  logic signed [ZW-1:0]    z_round;

  assign en      = !(out_valid_q && stall_i);
  assign stall_o = !en;

  vpg_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (valid_i),
    .v1_x_i   (v1_x_i),
    .v1_y_i   (v1_y_i),
    .v1_z_i   (v1_z_i),
    .v2_x_i   (v2_x_i),
    .v2_y_i   (v2_y_i),
    .v2_z_i   (v2_z_i),
    .valid_o  (f_valid),
    .side_o   (f_side),
    .sum_sq_o (f_sum)
  );

  assign sq_valid[0] = f_valid;
  assign sq_side[0]  = f_side;
  assign sq_rad[0]   = f_sum;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
    vpg_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .side_i  (sq_side[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_valid[i+1]),
      .side_o  (sq_side[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
  end

  // set-up: area, and the cordic start point from |dot| and |cross|
  always_comb begin
    root_inc       = {1'b0, sq_root[SQRT_STEPS]} + (ROOT_W+1)'(1);
    e_side_d       = sq_side[SQRT_STEPS];
    e_side_d.area  = AREA_W'(root_inc >> 1);
    dmag           = e_side_d.dot[DOT_W-1] ? DOT_W'(-e_side_d.dot) : DOT_W'(e_side_d.dot);
    if (e_side_d.dot[DOT_W-1]) begin
      e_x_d = NORM_W'(sq_root[SQRT_STEPS]);
      e_y_d = NORM_W'(dmag);
      e_z_d = HALF_PI_Z;
    end else begin
      e_x_d = NORM_W'(dmag);
      e_y_d = NORM_W'(sq_root[SQRT_STEPS]);
      e_z_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= sq_valid[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_side_q <= e_side_d;
      e_x_q    <= e_x_d;
      e_y_q    <= e_y_d;
      e_z_q    <= e_z_d;
    end
  end

  assign n_valid[0] = e_valid_q;
  assign n_side[0]  = e_side_q;
  assign n_x[0]     = e_x_q;
  assign n_y[0]     = e_y_q;
  assign n_z[0]     = e_z_q;

  // shifts of 32, 16, 8, 4, 2, 1 bring the leading one to the top bit
  for (genvar i = 0; i < NORM_STEPS; i++) begin : g_norm
    vpg_norm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .shift_i (STEP_W'(1 << (NORM_STEPS - 1 - i))),
      .valid_i (n_valid[i]),
      .side_i  (n_side[i]),
      .x_i     (n_x[i]),
      .y_i     (n_y[i]),
      .z_i     (n_z[i]),
      .valid_o (n_valid[i+1]),
      .side_o  (n_side[i+1]),
      .x_o     (n_x[i+1]),
      .y_o     (n_y[i+1]),
      .z_o     (n_z[i+1])
    );
  end

  assign c_valid[0] = n_valid[NORM_STEPS];
  assign c_side[0]  = n_side[NORM_STEPS];
  assign c_x[0]     = CW'(n_x[NORM_STEPS]);
  assign c_y[0]     = CW'(n_y[NORM_STEPS]);
  assign c_z[0]     = n_z[NORM_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    vpg_cordic_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .step_i  (STEP_W'(i)),
      .atan_i  (atan_z(i)),
      .valid_i (c_valid[i]),
      .side_i  (c_side[i]),
      .x_i     (c_x[i]),
      .y_i     (c_y[i]),
      .z_i     (c_z[i]),
      .valid_o (c_valid[i+1]),
      .side_o  (c_side[i+1]),
      .x_o     (c_x[i+1]),
      .y_o     (c_y[i+1]),
      .z_o     (c_z[i+1])
    );
  end

  // clamp to [0, pi], round from 2^-20 rad to Q2.14
  always_comb begin
    if (c_z[CORDIC_STEPS] < 0) begin
      z_clamped = '0;
    end else if (c_z[CORDIC_STEPS] > PI_Z) begin
      z_clamped = PI_Z;
    end else begin
      z_clamped = c_z[CORDIC_STEPS];
    end
    z_round     = z_clamped + ZW'(32);
    out_angle_d = c_side[CORDIC_STEPS].undef ? '0 : ANGLE_W'(z_round >>> 6);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_dot_q   <= c_side[CORDIC_STEPS].dot;
      out_angle_q <= out_angle_d;
      out_undef_q <= c_side[CORDIC_STEPS].undef;
      out_area_q  <= c_side[CORDIC_STEPS].area;
    end
  end

  assign valid_o           = out_valid_q;
  assign dot_value_o       = out_dot_q;
  assign angle_rad_o       = out_angle_q;
  assign angle_undefined_o = out_undef_q;
  assign triangle_area_o   = out_area_q;

  a_undef_zero_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && angle_undefined_o) |-> (angle_rad_o == '0))
    else $error("undefined angle not zero");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (angle_rad_o <= ANGLE_MAX))
    else $error("angle beyond pi");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i))
    else $error("input stalled without a waiting result");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(triangle_area_o) && $stable(dot_value_o)))
    else $error("result changed under stall");

endmodule
`default_nettype wire
